// ===== rtl/heap_kway_merger_defines.svh =====
// Assertion macros shared by the checker of the heap merger.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef HEAP_KWAY_MERGER_DEFINES_SVH
`define HEAP_KWAY_MERGER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HKM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked against the previous cycle's busy flag.
`define HKM_ASSERT_PAST_BUSY(label, ante, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> $past(busy)) \
        else $error(msg);

`endif

// ===== rtl/hkm_pkg.sv =====
// Package for the heap merger: sizes, item and heap entry types, state
// encoding and small index helpers. Depends on nothing.
package hkm_pkg;

    localparam int MAX_RUNS = 16;
    localparam int IDX_W    = $clog2(MAX_RUNS);
    localparam int CNT_W    = $clog2(MAX_RUNS + 1);
    localparam int CH_W     = IDX_W + 2;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] NUM_RUNS_RST = CFG_W'(16);

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         run_id;
        logic               last_in_run;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic [3:0]         run_id_res;
        logic               fetch_next;
        logic               merge_done;
        logic               last_of_step;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         run;
        logic               last;
    } entry_t;

    // Heap memory port controls driven by the sequencer.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr0;
        logic [IDX_W-1:0] raddr1;
    } ram_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_PUT,
        S_POP_RD,
        S_POP,
        S_DN_SEL,
        S_DN_CMP,
        S_DN_PUT
    } state_t;

    // Parent of a nonzero heap index.
    function automatic logic [IDX_W-1:0] parent_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] dec;
        dec = idx - IDX_W'(1);
        return dec >> 1;
    endfunction

    // Left child of a heap index, wide enough never to wrap.
    function automatic logic [CH_W-1:0] left_child(input logic [IDX_W-1:0] idx);
        return {1'b0, idx, 1'b1};
    endfunction

    function automatic logic [CH_W-1:0] size_ext(input logic [CNT_W-1:0] size);
        return CH_W'(size);
    endfunction

endpackage

// ===== rtl/hkm_key_cmp.sv =====
// Shared ordering compare for heap entries: value, then run, then last mark.
// Depends on hkm_pkg.
module hkm_key_cmp (
    input  hkm_pkg::entry_t a,
    input  hkm_pkg::entry_t b,
    output logic            lt
);

    logic [36:0] key_a;
    logic [36:0] key_b;

    // Flipping the sign bit makes the signed order an unsigned one.
    assign key_a = {~a.value[31], a.value[30:0], a.run, a.last};
    assign key_b = {~b.value[31], b.value[30:0], b.run, b.last};
    assign lt    = key_a < key_b;

endmodule

// ===== rtl/hkm_heap_ram.sv =====
// Heap storage: one write port and two registered read ports.
// Depends on hkm_pkg.
module hkm_heap_ram (
    input  logic              clk,
    input  hkm_pkg::ram_ctl_t ctl,
    output hkm_pkg::entry_t   rd0,
    output hkm_pkg::entry_t   rd1
);

    hkm_pkg::entry_t mem [hkm_pkg::MAX_RUNS];
    hkm_pkg::entry_t rd0_reg;
    hkm_pkg::entry_t rd1_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge clk)
    begin
        rd0_reg <= mem[ctl.raddr0];
        rd1_reg <= mem[ctl.raddr1];
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

// ===== rtl/hkm_ctrl.sv =====
// Sequencer of the heap merger: load phase, sift-up insert, pop and
// sift-down, all through one comparator and the heap memory.
// Depends on hkm_pkg.
module hkm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  hkm_pkg::in_item_t              item,
    input  logic                           cfg_we,
    input  logic [hkm_pkg::CFG_W-1:0]      cfg_wdata,
    input  hkm_pkg::entry_t                rd0,
    input  hkm_pkg::entry_t                rd1,
    input  logic                           cmp_lt,
    output hkm_pkg::ram_ctl_t              ram_ctl,
    output hkm_pkg::entry_t                cmp_a,
    output hkm_pkg::entry_t                cmp_b,
    output logic                           busy,
    output logic                           result_valid,
    output hkm_pkg::out_item_t             result
);

    localparam int IW = hkm_pkg::IDX_W;
    localparam int CW = hkm_pkg::CNT_W;
    localparam int HW = hkm_pkg::CH_W;

    hkm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   heap_size_reg, heap_size_next;
    logic [CW-1:0]   loaded_reg, loaded_next;
    logic [hkm_pkg::CFG_W-1:0] num_runs_reg;
    logic            pop_pend_reg, pop_pend_next;
    logic            pop_fetch_reg, pop_fetch_next;
    logic            res_valid_reg, res_valid_next;
    logic [IW-1:0]   hole_reg, hole_next;
    logic [IW-1:0]   win_idx_reg, win_idx_next;
    hkm_pkg::entry_t move_reg, move_next;
    hkm_pkg::entry_t win_reg, win_next;
    hkm_pkg::out_item_t res_reg, res_next;

    logic [CW-1:0]   eff_runs;
    logic [CW-1:0]   loaded_inc;
    logic            loading;
    logic            pop_now;
    logic            has_room;
    logic [IW-1:0]   up_parent;
    logic [CW-1:0]   size_m1;
    logic            root_fetch;
    logic [HW-1:0]   lc_root;
    logic            root_has_kids;
    logic [HW-1:0]   lc_sel;
    logic [HW-1:0]   rc_sel;
    logic            right_ok;
    logic [HW-1:0]   lc_win;
    logic            win_has_kids;
    hkm_pkg::entry_t in_entry;

    // Effective run count: zero acts as one, large values clamp to capacity.
    always_comb
    begin
        if (num_runs_reg == '0)
        begin
            eff_runs = CW'(1);
        end
        else if (int'(num_runs_reg) > hkm_pkg::MAX_RUNS)
        begin
            eff_runs = CW'(hkm_pkg::MAX_RUNS);
        end
        else
        begin
            eff_runs = CW'(num_runs_reg);
        end
    end

    // Shared decode terms.
    assign loaded_inc    = loaded_reg + CW'(1);
    assign loading       = loaded_reg < eff_runs;
    assign pop_now       = !(loading && (loaded_inc < eff_runs));
    assign has_room      = heap_size_reg < CW'(hkm_pkg::MAX_RUNS);
    assign up_parent     = hkm_pkg::parent_idx(hole_reg);
    assign size_m1       = heap_size_reg - CW'(1);
    assign root_fetch    = !rd0.last;
    assign lc_root       = hkm_pkg::left_child('0);
    assign root_has_kids = lc_root < hkm_pkg::size_ext(size_m1);
    assign lc_sel        = hkm_pkg::left_child(hole_reg);
    assign rc_sel        = lc_sel + HW'(1);
    assign right_ok      = rc_sel < hkm_pkg::size_ext(heap_size_reg);
    assign lc_win        = hkm_pkg::left_child(win_idx_reg);
    assign win_has_kids  = lc_win < hkm_pkg::size_ext(heap_size_reg);

    always_comb
    begin
        in_entry       = '0;
        in_entry.value = item.value;
        in_entry.run   = item.run_id;
        in_entry.last  = item.last_in_run;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hkm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (has_room && (heap_size_reg != '0))
                    begin
                        state_next = hkm_pkg::S_UP_CMP;
                    end
                    else if (pop_now)
                    begin
                        state_next = hkm_pkg::S_POP_RD;
                    end
                end
            end
            hkm_pkg::S_UP_CMP:
            begin
                if (cmp_lt)
                begin
                    if (up_parent == '0)
                    begin
                        state_next = hkm_pkg::S_UP_PUT;
                    end
                end
                else
                begin
                    state_next = pop_pend_reg ? hkm_pkg::S_POP_RD : hkm_pkg::S_IDLE;
                end
            end
            hkm_pkg::S_UP_PUT:
            begin
                state_next = pop_pend_reg ? hkm_pkg::S_POP_RD : hkm_pkg::S_IDLE;
            end
            hkm_pkg::S_POP_RD:
            begin
                state_next = hkm_pkg::S_POP;
            end
            hkm_pkg::S_POP:
            begin
                if (size_m1 == '0)
                begin
                    state_next = hkm_pkg::S_IDLE;
                end
                else if (root_has_kids)
                begin
                    state_next = hkm_pkg::S_DN_SEL;
                end
                else
                begin
                    state_next = hkm_pkg::S_DN_PUT;
                end
            end
            hkm_pkg::S_DN_SEL:
            begin
                state_next = hkm_pkg::S_DN_CMP;
            end
            hkm_pkg::S_DN_CMP:
            begin
                if (cmp_lt)
                begin
                    state_next = win_has_kids ? hkm_pkg::S_DN_SEL : hkm_pkg::S_DN_PUT;
                end
                else
                begin
                    state_next = pop_fetch_reg ? hkm_pkg::S_IDLE : hkm_pkg::S_POP_RD;
                end
            end
            hkm_pkg::S_DN_PUT:
            begin
                state_next = pop_fetch_reg ? hkm_pkg::S_IDLE : hkm_pkg::S_POP_RD;
            end
            default:
            begin
                state_next = hkm_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath controls and register updates for each state.
    always_comb
    begin
        ram_ctl         = '0;
        ram_ctl.waddr   = hole_reg;
        ram_ctl.wdata   = move_reg;
        cmp_a           = move_reg;
        cmp_b           = rd0;
        heap_size_next  = heap_size_reg;
        loaded_next     = loaded_reg;
        pop_pend_next   = pop_pend_reg;
        pop_fetch_next  = pop_fetch_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        hole_next       = hole_reg;
        win_idx_next    = win_idx_reg;
        move_next       = move_reg;
        win_next        = win_reg;
        case (state_reg)
            hkm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    move_next     = in_entry;
                    pop_pend_next = pop_now;
                    if (loading)
                    begin
                        loaded_next = loaded_inc;
                    end
                    // A full heap drops the item; the pops still run.
                    if (has_room)
                    begin
                        heap_size_next = heap_size_reg + CW'(1);
                        hole_next      = heap_size_reg[IW-1:0];
                        if (heap_size_reg == '0)
                        begin
                            ram_ctl.we    = 1'b1;
                            ram_ctl.waddr = '0;
                            ram_ctl.wdata = in_entry;
                        end
                        else
                        begin
                            ram_ctl.raddr0 = hkm_pkg::parent_idx(heap_size_reg[IW-1:0]);
                        end
                    end
                end
            end
            hkm_pkg::S_UP_CMP:
            begin
                // New entry against its parent: move the parent down or settle.
                cmp_a      = move_reg;
                cmp_b      = rd0;
                ram_ctl.we = 1'b1;
                if (cmp_lt)
                begin
                    ram_ctl.wdata  = rd0;
                    hole_next      = up_parent;
                    ram_ctl.raddr0 = hkm_pkg::parent_idx(up_parent);
                end
            end
            hkm_pkg::S_UP_PUT:
            begin
                ram_ctl.we = 1'b1;
            end
            hkm_pkg::S_POP_RD:
            begin
                ram_ctl.raddr0 = '0;
                ram_ctl.raddr1 = size_m1[IW-1:0];
            end
            hkm_pkg::S_POP:
            begin
                // Emit the root; the last entry becomes the sinking one.
                heap_size_next          = size_m1;
                res_valid_next          = 1'b1;
                res_next.value_res      = rd0.value;
                res_next.run_id_res     = rd0.run;
                res_next.fetch_next     = root_fetch;
                res_next.last_of_step   = root_fetch || (size_m1 == '0);
                res_next.merge_done     = !root_fetch && (size_m1 == '0);
                pop_fetch_next          = root_fetch;
                move_next               = rd1;
                hole_next               = '0;
                if ((size_m1 == '0) && !root_fetch)
                begin
                    loaded_next = '0;
                end
                ram_ctl.raddr0 = lc_root[IW-1:0];
                ram_ctl.raddr1 = IW'(lc_root + HW'(1));
            end
            hkm_pkg::S_DN_SEL:
            begin
                // Pick the smaller child.
                cmp_a = rd1;
                cmp_b = rd0;
                if (right_ok && cmp_lt)
                begin
                    win_next     = rd1;
                    win_idx_next = rc_sel[IW-1:0];
                end
                else
                begin
                    win_next     = rd0;
                    win_idx_next = lc_sel[IW-1:0];
                end
            end
            hkm_pkg::S_DN_CMP:
            begin
                // Smaller child against the sinking entry.
                cmp_a      = win_reg;
                cmp_b      = move_reg;
                ram_ctl.we = 1'b1;
                if (cmp_lt)
                begin
                    ram_ctl.wdata  = win_reg;
                    hole_next      = win_idx_reg;
                    ram_ctl.raddr0 = lc_win[IW-1:0];
                    ram_ctl.raddr1 = IW'(lc_win + HW'(1));
                end
            end
            hkm_pkg::S_DN_PUT:
            begin
                ram_ctl.we = 1'b1;
            end
            default:
            begin
                ram_ctl.we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hkm_pkg::S_IDLE;
            heap_size_reg <= '0;
            loaded_reg    <= '0;
            num_runs_reg  <= hkm_pkg::NUM_RUNS_RST;
            pop_pend_reg  <= 1'b0;
            pop_fetch_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heap_size_reg <= heap_size_next;
            loaded_reg    <= loaded_next;
            pop_pend_reg  <= pop_pend_next;
            pop_fetch_reg <= pop_fetch_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                num_runs_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hole_reg    <= hole_next;
        win_idx_reg <= win_idx_next;
        move_reg    <= move_next;
        win_reg     <= win_next;
        res_reg     <= res_next;
    end

    assign busy         = (state_reg != hkm_pkg::S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/heap_kway_merger.sv =====
// Top level of the k-way heap merger.
// Depends on hkm_pkg, hkm_ctrl, hkm_heap_ram and hkm_key_cmp.
//
// Usage: drive item and pulse start while busy is low; the item is taken
// at that clock edge. cfg_we with cfg_wdata sets the run count; the user
// must write it only while the block is idle, which the block itself does
// not enforce. The first run-count items load the heap and give no result,
// except the one that completes loading. Every later item is inserted,
// then the smallest entry is popped; popping goes on while the popped
// entry was the last of its run, until the heap is empty. Results appear
// on result with result_valid high for exactly one cycle; the receiver
// cannot stall, so each result must be taken when shown. An insert moves
// the new entry up one heap level per comparison and then settles it. A
// pop reads the root and the last entry, registers the root out as the
// result, then sinks the last entry one level per child select and
// compare, and writes it where it lands. The single comparator and the
// single write port of the heap memory make these steps run one after
// another. Items are handled one at a time; a final result may show in
// the first cycle with busy low. Reset clears the heap size, load count and
// sequencer and sets the run count to 16; heap contents are not cleared.
module heap_kway_merger (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  hkm_pkg::in_item_t         item,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic [hkm_pkg::CFG_W-1:0] cfg_wdata,
    output logic                      result_valid,
    output hkm_pkg::out_item_t        result
);

    hkm_pkg::ram_ctl_t ram_ctl;
    hkm_pkg::entry_t   rd0;
    hkm_pkg::entry_t   rd1;
    hkm_pkg::entry_t   cmp_a;
    hkm_pkg::entry_t   cmp_b;
    logic              cmp_lt;

    // Sequencer.
    hkm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .rd0          (rd0),
        .rd1          (rd1),
        .cmp_lt       (cmp_lt),
        .ram_ctl      (ram_ctl),
        .cmp_a        (cmp_a),
        .cmp_b        (cmp_b),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // Heap storage.
    hkm_heap_ram u_ram (
        .clk (clk),
        .ctl (ram_ctl),
        .rd0 (rd0),
        .rd1 (rd1)
    );

    // Shared comparator.
    hkm_key_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

endmodule

// ===== rtl/hkm_checker.sv =====
// Port-level checks for the heap merger and the bind that attaches them.
// Depends on hkm_pkg and heap_kway_merger_defines.svh.
`include "heap_kway_merger_defines.svh"

module hkm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               result_valid,
    input hkm_pkg::out_item_t result
);

    // A fetch request always ends the item's results.
    `HKM_ASSERT_NOW(a_fetch_ends_step, result_valid && result.fetch_next, result.last_of_step, "fetch_next without last_of_step")

    // Completion always ends the item's results.
    `HKM_ASSERT_NOW(a_done_ends_step, result_valid && result.merge_done, result.last_of_step, "merge_done without last_of_step")

    // A final result without a fetch request must close the merge.
    `HKM_ASSERT_NOW(a_end_kind, result_valid && result.last_of_step && !result.fetch_next, result.merge_done, "last result neither fetches nor completes")

    // More results pending keep the block busy.
    `HKM_ASSERT_NOW(a_busy_midstep, result_valid && !result.last_of_step, busy, "idle while results remain")

    // A result only follows a busy cycle.
    `HKM_ASSERT_PAST_BUSY(a_result_after_work, result_valid, "result without work")

endmodule

bind heap_kway_merger hkm_checker u_hkm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

// ===== dv/tb_heap_kway_merger.sv =====
// Self-checking testbench for heap_kway_merger: a directed table followed by
// reactive random merges, checked against an in-bench min-heap predictor.
// Depends on hkm_pkg and the heap_kway_merger RTL.
module tb_heap_kway_merger;

    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 38;
    localparam int NUM_PHASES   = 12;
    localparam int NOISE_PCT    = 10;
    localparam int TIMEOUT      = 6_000_000;
    localparam int NUM_DIR      = 19;

    // Run count used by each random phase, extremes and out-of-range codes included.
    localparam logic [hkm_pkg::CFG_W-1:0] PHASE_RUNS [NUM_PHASES] = '{
        5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd2, 5'd8, 5'd3, 5'd16, 5'd5, 5'd12, 5'd4
    };
    // Sender idle percentage per cycle, cycled over the phases.
    localparam int IDLE_PCT [3] = '{0, 79, 12};

    // One row of the directed table: optional run count write, then an item.
    typedef struct packed {
        logic                      do_cfg;
        logic [hkm_pkg::CFG_W-1:0] cfg;
        hkm_pkg::in_item_t         it;
        logic                      typed;
        hkm_pkg::out_item_t        res;
    } dir_row_t;

    localparam hkm_pkg::out_item_t NO_RES = '0;

    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // Single run: each item is loaded and popped at once.
        '{1'b1, 5'd1, '{32'h8000_0000, 4'd0, 1'b0}, 1'b1,
          '{32'h8000_0000, 4'd0, 1'b1, 1'b0, 1'b1}},
        '{1'b0, 5'd0, '{32'h7FFF_FFFF, 4'd15, 1'b1}, 1'b1,
          '{32'h7FFF_FFFF, 4'd15, 1'b0, 1'b1, 1'b1}},
        // A run count of zero behaves as one.
        '{1'b1, 5'd0, '{32'h0000_0000, 4'd5, 1'b1}, 1'b1,
          '{32'h0000_0000, 4'd5, 1'b0, 1'b1, 1'b1}},
        '{1'b0, 5'd0, '{32'hFFFF_FFFF, 4'd10, 1'b0}, 1'b1,
          '{32'hFFFF_FFFF, 4'd10, 1'b1, 1'b0, 1'b1}},
        // Run count raised mid-merge: loading resumes.
        '{1'b1, 5'd2, '{32'sd7, 4'd3, 1'b1}, 1'b0, NO_RES},
        // Equal value and run: the entry that is not last pops first.
        '{1'b0, 5'd0, '{32'sd7, 4'd3, 1'b1}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{32'sd7, 4'd3, 1'b0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{32'sd7, 4'd2, 1'b1}, 1'b0, NO_RES},
        // Duplicate run ids are merged like any other element.
        '{1'b1, 5'd3, '{-32'sd5, 4'd1, 1'b0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{-32'sd5, 4'd1, 1'b0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{-32'sd10, 4'd4, 1'b1}, 1'b0, NO_RES},
        '{1'b1, 5'd5, '{32'sd100, 4'd9, 1'b0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{-32'sd5, 4'd1, 1'b1}, 1'b0, NO_RES},
        // Run count lowered mid-merge, then a pop chain past exhausted runs.
        '{1'b1, 5'd1, '{32'sd55, 4'd6, 1'b1}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{32'h7FFF_FFFF, 4'd9, 1'b1}, 1'b0, NO_RES},
        // Ties at the most negative value across runs.
        '{1'b1, 5'd2, '{32'h8000_0000, 4'd15, 1'b0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{32'h8000_0000, 4'd14, 1'b0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{32'h8000_0000, 4'd14, 1'b1}, 1'b0, NO_RES},
        '{1'b0, 5'd0, '{32'h7FFF_FFFF, 4'd15, 1'b1}, 1'b0, NO_RES}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    hkm_pkg::in_item_t         item;
    logic                      busy;
    logic                      cfg_we;
    logic [hkm_pkg::CFG_W-1:0] cfg_wdata;
    logic                      result_valid;
    hkm_pkg::out_item_t        result;

    // Predictor state: heap contents, load progress and run count.
    hkm_pkg::entry_t           heap_ent [hkm_pkg::MAX_RUNS];
    int                        heap_cnt;
    int                        loaded_cnt;
    logic [hkm_pkg::CFG_W-1:0] run_count;
    int                        want_run;
    hkm_pkg::out_item_t        step_out [$];
    hkm_pkg::out_item_t        expected_q [$];
    int                        errors = 0;

    // Stimulus plan: sorted runs whose next element is handed out on request.
    int                        run_left [hkm_pkg::MAX_RUNS];
    longint                    run_next [hkm_pkg::MAX_RUNS];
    int                        load_order [hkm_pkg::MAX_RUNS];
    bit                        narrow_plan;

    hkm_pkg::out_item_t        want_res;
    hkm_pkg::in_item_t         stim;
    int                        ph;
    int                        n;

    heap_kway_merger DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT);
        $display("Regression FAIL");
        $finish;
    end

    // Smaller value first, then lower run, then not-last before last.
    function automatic logic [36:0] order_key(hkm_pkg::entry_t e);
        return {~e.value[31], e.value[30:0], e.run, e.last};
    endfunction

    function automatic int eff_runs();
        if (run_count == 0)
            return 1;
        if (run_count > hkm_pkg::MAX_RUNS)
            return hkm_pkg::MAX_RUNS;
        return int'(run_count);
    endfunction

    function automatic hkm_pkg::in_item_t noise_item();
        hkm_pkg::in_item_t it;
        it.value       = $urandom;
        it.run_id      = 4'($urandom_range(0, 15));
        it.last_in_run = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic swap_ent(input int a, input int b);
        hkm_pkg::entry_t t;
        t           = heap_ent[a];
        heap_ent[a] = heap_ent[b];
        heap_ent[b] = t;
    endtask

    task automatic heap_insert(input hkm_pkg::entry_t e);
        int i;
        int p;
        if (heap_cnt >= hkm_pkg::MAX_RUNS)
            return;
        i = heap_cnt;
        heap_cnt++;
        heap_ent[i] = e;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (order_key(heap_ent[i]) < order_key(heap_ent[p]))
            begin
                swap_ent(i, p);
                i = p;
            end
            else
                break;
        end
    endtask

    task automatic heap_pop_min(output hkm_pkg::entry_t e);
        int i;
        int lc;
        int m;
        e = heap_ent[0];
        heap_cnt--;
        if (heap_cnt == 0)
            return;
        heap_ent[0] = heap_ent[heap_cnt];
        i = 0;
        forever
        begin
            lc = 2 * i + 1;
            if (lc >= heap_cnt)
                break;
            m = lc;
            if (lc + 1 < heap_cnt && order_key(heap_ent[lc + 1]) < order_key(heap_ent[lc]))
                m = lc + 1;
            if (order_key(heap_ent[m]) < order_key(heap_ent[i]))
            begin
                swap_ent(i, m);
                i = m;
            end
            else
                break;
        end
    endtask

    // Work out the results one accepted item causes and advance the state.
    task automatic merge_step(input hkm_pkg::in_item_t it);
        int                 eff;
        hkm_pkg::entry_t    e;
        hkm_pkg::entry_t    p;
        hkm_pkg::out_item_t o;
        bit                 fetch;
        eff = eff_runs();
        step_out.delete();
        e.value = it.value;
        e.run   = it.run_id;
        e.last  = it.last_in_run;
        heap_insert(e);
        if (loaded_cnt < eff)
        begin
            loaded_cnt++;
            if (loaded_cnt < eff)
                return;
        end
        fetch = 1'b0;
        while (heap_cnt > 0 && step_out.size() < hkm_pkg::MAX_RUNS)
        begin
            heap_pop_min(p);
            fetch = !p.last;
            o = '0;
            o.value_res  = p.value;
            o.run_id_res = p.run;
            o.fetch_next = fetch;
            step_out = {step_out, o};
            if (fetch)
                break;
        end
        if (step_out.size() > 0)
        begin
            o = step_out[step_out.size() - 1];
            o.last_of_step = 1'b1;
            if (!fetch && heap_cnt == 0)
            begin
                o.merge_done = 1'b1;
                loaded_cnt   = 0;
            end
            step_out[step_out.size() - 1] = o;
            want_run = fetch ? int'(p.run) : -1;
        end
    endtask

    // Fresh set of sorted runs for a new merge, heads loaded in random order.
    task automatic plan_merge();
        int i;
        int j;
        int t;
        narrow_plan = ($urandom_range(0, 3) == 0);
        for (i = 0; i < hkm_pkg::MAX_RUNS; i++)
            load_order[i] = i;
        for (i = hkm_pkg::MAX_RUNS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = load_order[i];
            load_order[i] = load_order[j];
            load_order[j] = t;
        end
        for (i = 0; i < hkm_pkg::MAX_RUNS; i++)
        begin
            run_left[i] = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 12)
                                                        : $urandom_range(1, 4);
            if (narrow_plan)
                run_next[i] = longint'($urandom_range(0, 6)) - 3;
            else
                case ($urandom_range(0, 7))
                    0:       run_next[i] = -64'sd2147483648;
                    1:       run_next[i] = 64'sd2147483647 - $urandom_range(0, 3);
                    default: run_next[i] = longint'($signed($urandom));
                endcase
        end
    endtask

    // Next element of run r; a run asked for past its end gets a last element.
    task automatic next_elem(input int r, output hkm_pkg::in_item_t it);
        longint nv;
        it.value  = run_next[r][31:0];
        it.run_id = r[3:0];
        if (run_left[r] > 0)
        begin
            run_left[r]--;
            it.last_in_run = (run_left[r] == 0);
        end
        else
            it.last_in_run = 1'b1;
        if (narrow_plan)
            nv = run_next[r] + $urandom_range(0, 2);
        else if ($urandom_range(0, 9) == 0)
            nv = run_next[r] + longint'($urandom);
        else
            nv = run_next[r] + $urandom_range(0, 1000);
        if (nv > 64'sd2147483647)
            nv = 64'sd2147483647;
        run_next[r] = nv;
    endtask

    // Mostly well-formed merges driven by the predicted fetch requests.
    task automatic pick_item(output hkm_pkg::in_item_t it);
        if (loaded_cnt == 0)
            plan_merge();
        if ($urandom_range(0, 99) < NOISE_PCT)
            it = noise_item();
        else if (loaded_cnt < eff_runs())
            next_elem(load_order[loaded_cnt], it);
        else if (want_run >= 0)
            next_elem(want_run, it);
        else
            it = noise_item();
    endtask

    // Present an item until it is taken, then queue what it should produce.
    task automatic send_item(input hkm_pkg::in_item_t it, input bit use_typed,
                             input hkm_pkg::out_item_t typed_res);
        int k;
        start <= 1'b1;
        item  <= it;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        merge_step(it);
        if (use_typed)
            expected_q = {expected_q, typed_res};
        else
            for (k = 0; k < step_out.size(); k++)
                expected_q = {expected_q, step_out[k]};
    endtask

    // Write the run count once the block has gone quiet.
    task automatic set_run_count(input logic [hkm_pkg::CFG_W-1:0] v);
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        run_count = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare every result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, result);
                errors++;
            end
            else
            begin
                want_res = expected_q.pop_front();
                check_field("value_res", want_res.value_res, result.value_res);
                check_field("run_id_res", 32'(want_res.run_id_res), 32'(result.run_id_res));
                check_field("fetch_next", 32'(want_res.fetch_next), 32'(result.fetch_next));
                check_field("merge_done", 32'(want_res.merge_done), 32'(result.merge_done));
                check_field("last_of_step", 32'(want_res.last_of_step),
                            32'(result.last_of_step));
            end
        end
    end

    initial
    begin
        start      <= 1'b0;
        item       <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        rst_n      <= 1'b0;
        heap_cnt   = 0;
        loaded_cnt = 0;
        run_count  = hkm_pkg::NUM_RUNS_RST;
        want_run   = -1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back.
        for (n = 0; n < NUM_DIR; n++)
        begin
            if (DIR_ROWS[n].do_cfg)
                set_run_count(DIR_ROWS[n].cfg);
            send_item(DIR_ROWS[n].it, DIR_ROWS[n].typed, DIR_ROWS[n].res);
        end

        // Random phases, each with its own run count and sender idling.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_run_count(PHASE_RUNS[ph]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // The sender decides cycle by cycle whether to stay idle.
                while ($urandom_range(0, 99) < IDLE_PCT[ph % 3])
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                pick_item(stim);
                send_item(stim, 1'b0, NO_RES);
            end
        end

        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
